// ----- hdl/reflow_profile_sequencer_assert.svh -----
// Assertion macros shared by the sequencer modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef REFLOW_PROFILE_SEQUENCER_ASSERT_SVH
`define REFLOW_PROFILE_SEQUENCER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rps_pkg.sv -----
`default_nettype none

package rps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEAT_RATE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOAK_TEMP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOAK_HOLD_MS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEATUP_RATE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_TEMP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_HOLD_MS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOL_RATE     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOL_END_TEMP = 3'd7;

    localparam logic [10:0] RST_PREHEAT_RATE  = 11'd500;
    localparam logic [11:0] RST_SOAK_TEMP     = 12'd2400;
    localparam logic [17:0] RST_SOAK_HOLD_MS  = 18'd60000;
    localparam logic [11:0] RST_HEATUP_RATE   = 12'd1000;
    localparam logic [11:0] RST_PEAK_TEMP     = 12'd3520;
    localparam logic [16:0] RST_PEAK_HOLD_MS  = 17'd30000;
    localparam logic [12:0] RST_COOL_RATE     = 13'd1000;
    localparam logic [10:0] RST_COOL_END_TEMP = 11'd800;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PREHEAT  = 3'd1;
    localparam logic [2:0] PH_SOAK     = 3'd2;
    localparam logic [2:0] PH_HEATUP   = 3'd3;
    localparam logic [2:0] PH_REFLOW   = 3'd4;
    localparam logic [2:0] PH_COOLDOWN = 3'd5;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [2:0] MODE_KEEP  = 3'd0;
    localparam logic [2:0] MODE_IDLE  = 3'd1;
    localparam logic [2:0] MODE_FIXED = 3'd2;
    localparam logic [2:0] MODE_UP    = 3'd3;
    localparam logic [2:0] MODE_DOWN  = 3'd4;

    localparam logic [13:0]        ROOM_TEMP  = 14'd400;
    localparam logic signed [13:0] SAFE_LIMIT = 14'sd4000;
    localparam logic [31:0]        TIMEOUT_MS = 32'd600000;
    localparam logic [15:0]        RAMP_DIV   = 16'd62500;

    // floor(x / 62500) for x < 2^30
    localparam logic [30:0] RECIP_Q = 31'd1125899907;
    localparam int          SHIFT_Q = 46;
    // floor(x / 62500) for x < 2^29
    localparam logic [29:0] RECIP_F = 30'd562949954;
    localparam int          SHIFT_F = 45;
    // floor(x / 1000) for x < 2^32
    localparam logic [32:0] RECIP_S = 33'd4398046512;
    localparam int          SHIFT_S = 42;

    typedef struct packed {
        logic [10:0] preheat_rate;
        logic [11:0] soak_temp;
        logic [17:0] soak_hold_ms;
        logic [11:0] heatup_rate;
        logic [11:0] peak_temp;
        logic [16:0] peak_hold_ms;
        logic [12:0] cool_rate;
        logic [10:0] cool_end_temp;
    } t_cfg;

    typedef struct packed {
        logic        tick;
        logic        accepted;
        logic [2:0]  phase;
        logic        emergency;
        logic [2:0]  mode;
        logic [12:0] rate;
        logic [11:0] limit;
        logic [13:0] entry;
        logic [29:0] ecl;
        logic [31:0] elapsed;
    } t_item;

    typedef struct packed {
        logic [22:0] phase_elapsed_s;
        logic        emergency;
        logic        accepted;
        logic [2:0]  phase;
        logic [13:0] setpoint;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/rps_cfg_regs.sv -----
`default_nettype none

module rps_cfg_regs
    import rps_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wr_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preheat_rate  <= RST_PREHEAT_RATE;
            r_cfg.soak_temp     <= RST_SOAK_TEMP;
            r_cfg.soak_hold_ms  <= RST_SOAK_HOLD_MS;
            r_cfg.heatup_rate   <= RST_HEATUP_RATE;
            r_cfg.peak_temp     <= RST_PEAK_TEMP;
            r_cfg.peak_hold_ms  <= RST_PEAK_HOLD_MS;
            r_cfg.cool_rate     <= RST_COOL_RATE;
            r_cfg.cool_end_temp <= RST_COOL_END_TEMP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PREHEAT_RATE:  r_cfg.preheat_rate  <= i_cfg_wr_data[10:0];
                CFG_SOAK_TEMP:     r_cfg.soak_temp     <= i_cfg_wr_data[11:0];
                CFG_SOAK_HOLD_MS:  r_cfg.soak_hold_ms  <= i_cfg_wr_data[17:0];
                CFG_HEATUP_RATE:   r_cfg.heatup_rate   <= i_cfg_wr_data[11:0];
                CFG_PEAK_TEMP:     r_cfg.peak_temp     <= i_cfg_wr_data[11:0];
                CFG_PEAK_HOLD_MS:  r_cfg.peak_hold_ms  <= i_cfg_wr_data[16:0];
                CFG_COOL_RATE:     r_cfg.cool_rate     <= i_cfg_wr_data[12:0];
                CFG_COOL_END_TEMP: r_cfg.cool_end_temp <= i_cfg_wr_data[10:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/rps_phase_ctrl.sv -----
`default_nettype none
`include "reflow_profile_sequencer_assert.svh"

module rps_phase_ctrl
    import rps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [13:0] i_temp,
    input  wire logic [31:0] i_time,
    output logic             o_item_valid,
    output t_item            o_item,
    input  wire logic        i_item_ready
);

    logic        r_v0;
    logic [1:0]  r_func;
    logic [13:0] r_temp;
    logic [31:0] r_time;

    logic        r_v1;
    t_item       r_item;

    logic [2:0]  r_cur;
    logic [2:0]  r_req;
    logic [31:0] r_start;
    logic [13:0] r_entry;
    logic        r_emer;

    logic [2:0]  n_cur;
    logic [2:0]  n_req;
    logic [31:0] n_start;
    logic [13:0] n_entry;
    logic        n_emer;
    t_item       n_item;

    logic        w_rdy0;
    logic        w_rdy1;
    logic        w_move;

    logic signed [13:0] w_temp_s;
    logic signed [13:0] w_soak_s;
    logic signed [13:0] w_peak_s;
    logic signed [13:0] w_cool_s;
    logic        w_over;
    logic [2:0]  w_req_a;
    logic        w_enter;
    logic [2:0]  w_cur_a;
    logic [31:0] w_run;
    logic [31:0] w_elapsed;
    logic        w_emer_a;
    logic [13:0] w_entry_a;
    logic        w_tmo;
    logic [2:0]  w_req_b;

    assign w_rdy1 = !r_v1 || i_item_ready;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign w_move = r_v0 && w_rdy1;
    assign o_ready = w_rdy0;

    assign w_temp_s = r_temp;
    assign w_soak_s = {2'b00, i_cfg.soak_temp};
    assign w_peak_s = {2'b00, i_cfg.peak_temp};
    assign w_cool_s = {3'b000, i_cfg.cool_end_temp};

    assign w_over    = w_temp_s > SAFE_LIMIT;
    assign w_req_a   = w_over ? PH_IDLE : r_req;
    assign w_enter   = w_req_a != r_cur;
    assign w_cur_a   = w_enter ? w_req_a : r_cur;
    assign w_run     = r_time - r_start;
    assign w_elapsed = w_enter ? 32'd0 : w_run;
    assign w_emer_a  = (w_enter && (w_req_a == PH_IDLE)) ? 1'b0 : (w_over || r_emer);
    assign w_entry_a = w_enter ? r_temp : r_entry;
    assign w_tmo     = (w_elapsed > TIMEOUT_MS) && (w_cur_a != PH_IDLE);
    assign w_req_b   = w_tmo ? PH_COOLDOWN : w_req_a;

    always_comb begin
        n_cur   = r_cur;
        n_req   = r_req;
        n_start = r_start;
        n_entry = r_entry;
        n_emer  = r_emer;

        n_item           = '0;
        n_item.phase     = r_cur;
        n_item.emergency = r_emer;
        n_item.mode      = MODE_KEEP;

        case (r_func)
            FUNC_START: begin
                if (r_cur == PH_IDLE) begin
                    n_req           = PH_PREHEAT;
                    n_item.accepted = 1'b1;
                end
            end
            FUNC_STOP: begin
                if (r_cur != PH_IDLE) begin
                    n_req           = PH_COOLDOWN;
                    n_item.accepted = 1'b1;
                end
            end
            FUNC_TICK: begin
                n_cur   = w_cur_a;
                n_start = w_enter ? r_time : r_start;
                n_entry = w_entry_a;
                n_emer  = w_emer_a;
                n_req   = w_req_b;

                n_item.tick      = 1'b1;
                n_item.accepted  = 1'b1;
                n_item.phase     = w_cur_a;
                n_item.emergency = w_emer_a;
                n_item.entry     = w_entry_a;
                n_item.elapsed   = w_elapsed;
                n_item.ecl       = (w_elapsed[31:30] != 2'b00) ? '1 : w_elapsed[29:0];

                case (w_cur_a)
                    PH_PREHEAT: begin
                        n_item.mode  = MODE_UP;
                        n_item.rate  = {2'b00, i_cfg.preheat_rate};
                        n_item.limit = i_cfg.soak_temp;
                        if (w_temp_s >= w_soak_s) begin
                            n_req = PH_SOAK;
                        end
                    end
                    PH_SOAK: begin
                        n_item.mode  = MODE_FIXED;
                        n_item.limit = i_cfg.soak_temp;
                        if (w_elapsed >= {14'd0, i_cfg.soak_hold_ms}) begin
                            n_req = PH_HEATUP;
                        end
                    end
                    PH_HEATUP: begin
                        n_item.mode  = MODE_UP;
                        n_item.rate  = {1'b0, i_cfg.heatup_rate};
                        n_item.limit = i_cfg.peak_temp;
                        if (w_temp_s >= w_peak_s) begin
                            n_req = PH_REFLOW;
                        end
                    end
                    PH_REFLOW: begin
                        n_item.mode  = MODE_FIXED;
                        n_item.limit = i_cfg.peak_temp;
                        if (w_elapsed >= {15'd0, i_cfg.peak_hold_ms}) begin
                            n_req = PH_COOLDOWN;
                        end
                    end
                    PH_COOLDOWN: begin
                        n_item.mode  = MODE_DOWN;
                        n_item.rate  = i_cfg.cool_rate;
                        n_item.limit = {1'b0, i_cfg.cool_end_temp};
                        if (w_temp_s <= w_cool_s) begin
                            n_req = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        n_item.mode = MODE_IDLE;
                    end
                    default: begin
                        n_item.mode = MODE_KEEP;
                        n_req       = PH_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_cur   <= PH_IDLE;
            r_req   <= PH_IDLE;
            r_start <= 32'd0;
            r_entry <= ROOM_TEMP;
            r_emer  <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_move) begin
                r_cur   <= n_cur;
                r_req   <= n_req;
                r_start <= n_start;
                r_entry <= n_entry;
                r_emer  <= n_emer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_func <= i_func;
            r_temp <= i_temp;
            r_time <= i_time;
        end
        if (w_move) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_v1;
    assign o_item       = r_item;

    `RPS_ASSERT_NXT(a_over_temp_idle, w_move && (r_func == FUNC_TICK) && w_over,
        (r_req == PH_IDLE) && (r_item.phase == PH_IDLE), "over-temperature did not force idle")
    `RPS_ASSERT_NXT(a_start_from_idle,
        w_move && (r_func == FUNC_START) && (r_cur == PH_IDLE),
        (r_req == PH_PREHEAT) && r_item.accepted, "start from idle not taken")
    `RPS_ASSERT_NXT(a_state_hold, !w_move,
        $stable(r_cur) && $stable(r_req) && $stable(r_start), "state moved without a transaction")

endmodule

`default_nettype wire

// ----- hdl/rps_ramp_pipe.sv -----
`default_nettype none
`include "reflow_profile_sequencer_assert.svh"

module rps_ramp_pipe
    import rps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_item_ready,
    output logic       o_valid,
    output t_result    o_result,
    input  wire logic  i_ready
);

    logic        r_va;
    logic        r_vb;
    logic        r_vc;
    logic        r_vd;
    logic        r_vo;

    t_item       r_a_item;
    logic [14:0] r_a_q;
    logic [22:0] r_a_sec;

    t_item       r_b_item;
    logic [15:0] r_b_rem;
    logic [27:0] r_b_rq;
    logic [22:0] r_b_sec;

    t_item       r_c_item;
    logic [28:0] r_c_x;
    logic [27:0] r_c_rq;
    logic [22:0] r_c_sec;

    t_item       r_d_item;
    logic [12:0] r_d_f;
    logic [27:0] r_d_rq;
    logic [22:0] r_d_sec;

    logic [13:0] r_target;
    logic [2:0]  r_o_phase;
    logic        r_o_acc;
    logic        r_o_emer;
    logic [22:0] r_o_sec;

    logic [13:0] n_target;

    logic        w_rdy_a;
    logic        w_rdy_b;
    logic        w_rdy_c;
    logic        w_rdy_d;
    logic        w_rdy_o;
    logic        w_load_o;

    logic [60:0] w_prod_q;
    logic [64:0] w_prod_s;
    logic [30:0] w_qd;
    logic [29:0] w_rem30;
    logic [27:0] w_rq;
    logic [28:0] w_x;
    logic [58:0] w_prod_f;
    logic [28:0] w_ramp;

    logic signed [30:0] w_entry_x;
    logic signed [30:0] w_ramp_x;
    logic signed [30:0] w_lim_x;
    logic signed [30:0] w_up;
    logic signed [30:0] w_dn;

    assign w_rdy_o = !r_vo || i_ready;
    assign w_rdy_d = !r_vd || w_rdy_o;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign w_load_o = r_vd && w_rdy_o;
    assign o_item_ready = w_rdy_a;

    // quotient by 62500 and whole seconds
    assign w_prod_q = 61'(i_item.ecl) * 61'(RECIP_Q);
    assign w_prod_s = 65'(i_item.elapsed) * 65'(RECIP_S);

    // remainder and rate times quotient
    assign w_qd    = 31'(r_a_q) * 31'(RAMP_DIV);
    assign w_rem30 = r_a_item.ecl - w_qd[29:0];
    assign w_rq    = 28'(r_a_item.rate) * 28'(r_a_q);

    // rate times remainder, below 2^29
    assign w_x = 29'(r_b_item.rate) * 29'(r_b_rem);

    // fractional part of the ramp
    assign w_prod_f = 59'(r_c_x) * 59'(RECIP_F);

    assign w_ramp    = 29'(r_d_rq) + 29'(r_d_f);
    assign w_entry_x = {{17{r_d_item.entry[13]}}, r_d_item.entry};
    assign w_ramp_x  = {2'b00, w_ramp};
    assign w_lim_x   = {19'd0, r_d_item.limit};
    assign w_up      = w_entry_x + w_ramp_x;
    assign w_dn      = w_entry_x - w_ramp_x;

    always_comb begin
        case (r_d_item.mode)
            MODE_KEEP:  n_target = r_target;
            MODE_IDLE:  n_target = ROOM_TEMP;
            MODE_FIXED: n_target = {2'b00, r_d_item.limit};
            MODE_UP:    n_target = (w_up > w_lim_x) ? {2'b00, r_d_item.limit} : w_up[13:0];
            MODE_DOWN:  n_target = (w_dn < w_lim_x) ? {2'b00, r_d_item.limit} : w_dn[13:0];
            default:    n_target = r_target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_vc     <= 1'b0;
            r_vd     <= 1'b0;
            r_vo     <= 1'b0;
            r_target <= ROOM_TEMP;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_item_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
            if (w_rdy_c) begin
                r_vc <= r_vb;
            end
            if (w_rdy_d) begin
                r_vd <= r_vc;
            end
            if (w_rdy_o) begin
                r_vo <= r_vd;
            end
            if (w_load_o) begin
                r_target <= n_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_item_valid) begin
            r_a_item <= i_item;
            r_a_q    <= w_prod_q[SHIFT_Q+14:SHIFT_Q];
            r_a_sec  <= w_prod_s[SHIFT_S+22:SHIFT_S];
        end
        if (w_rdy_b && r_va) begin
            r_b_item <= r_a_item;
            r_b_rem  <= w_rem30[15:0];
            r_b_rq   <= w_rq;
            r_b_sec  <= r_a_sec;
        end
        if (w_rdy_c && r_vb) begin
            r_c_item <= r_b_item;
            r_c_x    <= w_x;
            r_c_rq   <= r_b_rq;
            r_c_sec  <= r_b_sec;
        end
        if (w_rdy_d && r_vc) begin
            r_d_item <= r_c_item;
            r_d_f    <= w_prod_f[SHIFT_F+12:SHIFT_F];
            r_d_rq   <= r_c_rq;
            r_d_sec  <= r_c_sec;
        end
        if (w_load_o) begin
            r_o_phase <= r_d_item.phase;
            r_o_acc   <= r_d_item.accepted;
            r_o_emer  <= r_d_item.emergency;
            r_o_sec   <= r_d_sec;
        end
    end

    assign o_valid                  = r_vo;
    assign o_result.setpoint        = r_target;
    assign o_result.phase           = r_o_phase;
    assign o_result.accepted        = r_o_acc;
    assign o_result.emergency       = r_o_emer;
    assign o_result.phase_elapsed_s = r_o_sec;

    `RPS_ASSERT_NXT(a_request_keeps_setpoint, w_load_o && !r_d_item.tick,
        $stable(r_target), "request transaction changed the setpoint")
    `RPS_ASSERT_NXT(a_idle_tick_room_temp, w_load_o && r_d_item.tick && (r_d_item.phase == PH_IDLE),
        r_target == ROOM_TEMP, "idle tick setpoint is not room temperature")
    `RPS_ASSERT_NXT(a_request_zero_seconds, w_load_o && !r_d_item.tick,
        r_o_sec == 23'd0, "request transaction reports elapsed seconds")

endmodule

`default_nettype wire

// ----- hdl/reflow_profile_sequencer.sv -----
// Throughput: one transaction per cycle; the seven-stage pipeline stalls only when
// the result register is full and not taken, and a full pipe holds seven items.
// Reset (i_rst_n low, synchronous): phase idle, setpoint 400, configuration at its
// defaults, items in flight dropped.
`default_nettype none

module reflow_profile_sequencer
    import rps_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // temperature[13:0], time_ms[45:14], zero fill
    input  wire logic [47:0]            i_s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]             i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // setpoint[13:0], phase[16:14], accepted[17], emergency[18],
    // phase_elapsed_s[41:19], zero fill
    output logic [47:0]                 o_m_axis_tdata
);

    t_cfg    w_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_ready;
    t_result w_result;

    rps_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    rps_phase_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_func       (i_s_axis_tuser),
        .i_temp       (i_s_axis_tdata[13:0]),
        .i_time       (i_s_axis_tdata[45:14]),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ready (w_item_ready)
    );

    rps_ramp_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .o_valid      (o_m_axis_tvalid),
        .o_result     (w_result),
        .i_ready      (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'd0, w_result};

endmodule

`default_nettype wire
